### src/lcd4_pkg.sv
// shared types, codes and constants for the 4-bit character lcd sequencer
package lcd4_pkg;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [2:0] CFG_PULSE    = 3'd0;
    localparam logic [2:0] CFG_SETTLE   = 3'd1;
    localparam logic [2:0] CFG_WAKE     = 3'd2;
    localparam logic [2:0] CFG_INIT_CMD = 3'd3;
    localparam logic [2:0] CFG_CLEAR    = 3'd4;
    localparam logic [2:0] CFG_WRAP_COL = 3'd5;
    localparam logic [2:0] CFG_WRAP_ADR = 3'd6;

    localparam logic [4:0] COLUMN_MAX = 5'd31;

    localparam logic [7:0] CLEAR_BYTE = 8'h01;

    // step numbers within one job
    localparam logic [3:0] STEP_BYTE_LO  = 4'd1;
    localparam logic [3:0] STEP_WRAP_LO  = 4'd3;
    localparam logic [3:0] STEP_WAKE_END = 4'd3;
    localparam logic [3:0] STEP_INIT_END = 4'd11;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] byte_value;
        logic       start_of_text;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        rs;
        logic [16:0] wait_after;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [15:0] wake_ticks;
        logic [15:0] init_cmd_ticks;
        logic [15:0] clear_ticks;
        logic [4:0]  wrap_column;
        logic [7:0]  wrap_address;
    } t_cfg;

    // one classified request as handed from front to back
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] byte_value;
        logic       wrap;
    } t_job;

    // init command bytes after the wake-up nibbles
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h28;
            2'd1:    b = 8'h0C;
            2'd2:    b = 8'h06;
            default: b = 8'h80;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] wake_nibble(input logic [1:0] idx);
        logic [3:0] n;
        case (idx)
            2'd3:    n = 4'h2;
            default: n = 4'h3;
        endcase
        return n;
    endfunction

endpackage

### src/lcd4_front.sv
// front end: accepts requests, tracks the text column and decides line wraps
module lcd4_front
    import lcd4_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  logic [4:0] i_wrap_column,
    output t_job     o_job
);

    logic [4:0] r_column;
    logic [4:0] n_column;
    logic [4:0] col_base;
    logic       is_data;

    assign is_data  = (i_item.command == CMD_DATA);
    assign col_base = i_item.start_of_text ? 5'd0 : r_column;
    assign n_column = (col_base < COLUMN_MAX) ? col_base + 5'd1 : col_base;

    always_comb begin
        o_job.command    = i_item.command;
        o_job.byte_value = i_item.byte_value;
        o_job.wrap       = is_data && (n_column == i_wrap_column);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= 5'd0;
        end else if (i_accept && is_data) begin
            r_column <= n_column;
        end
    end

endmodule

### src/lcd4_queue.sv
// two-entry job queue between front and back
module lcd4_queue
    import lcd4_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("job queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("job queue pointers disagree with count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("job queue count missed a push");

endmodule

### src/lcd4_back.sv
// back end: expands one job into its run of strobes, one per cycle while the output register is empty or popped
module lcd4_back
    import lcd4_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_empty,
    input  t_job      i_q_job,
    output logic      o_q_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    logic        r_busy;
    t_job        r_job;
    logic [3:0]  r_step;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        advance;
    logic        load;
    t_out_item   strobe;
    logic [7:0]  cur_byte;
    logic [15:0] extra;
    logic        hi_half;
    logic        is_wake;
    logic [2:0]  init_idx;

    assign load    = !r_busy && !i_q_empty;
    assign o_q_pop = load;
    assign advance = r_busy && (!r_out_valid || i_pop);
    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    assign hi_half  = !r_step[0];
    assign is_wake  = (r_job.command == CMD_INIT) && (r_step <= STEP_WAKE_END);
    // init command bytes start at step four, two steps each
    assign init_idx = r_step[3:1] - 3'd2;

    always_comb begin
        cur_byte = r_job.byte_value;
        extra    = 16'd0;
        strobe.rs   = 1'b0;
        strobe.last = 1'b0;
        case (r_job.command)
            CMD_INIT: begin
                cur_byte    = init_byte(init_idx[1:0]);
                extra       = (init_idx == 3'd0) ? i_cfg.wake_ticks : i_cfg.init_cmd_ticks;
                strobe.last = (r_step == STEP_INIT_END);
            end
            CMD_BYTE: begin
                strobe.last = (r_step == STEP_BYTE_LO);
            end
            CMD_DATA: begin
                if (r_step[1]) begin
                    cur_byte = i_cfg.wrap_address;
                end else begin
                    strobe.rs = 1'b1;
                end
                strobe.last = r_job.wrap ? (r_step == STEP_WRAP_LO)
                                         : (r_step == STEP_BYTE_LO);
            end
            CMD_CLEAR: begin
                cur_byte    = CLEAR_BYTE;
                extra       = i_cfg.clear_ticks;
                strobe.last = (r_step == STEP_BYTE_LO);
            end
            default: begin
                cur_byte = r_job.byte_value;
            end
        endcase

        if (is_wake) begin
            strobe.nibble     = wake_nibble(r_step[1:0]);
            strobe.wait_after = {1'b0, i_cfg.wake_ticks};
        end else if (hi_half) begin
            strobe.nibble     = cur_byte[7:4];
            strobe.wait_after = 17'd0;
        end else begin
            strobe.nibble     = cur_byte[3:0];
            strobe.wait_after = {1'b0, i_cfg.settle_ticks} + {1'b0, extra};
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
        if (advance) begin
            r_out <= strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_step <= 4'd0;
            end else if (advance) begin
                r_step <= r_step + 4'd1;
                if (strobe.last) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_INIT_END))
        else $error("strobe step past end of init run");

    a_short_jobs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_job.command != CMD_INIT) |-> (r_step <= STEP_WRAP_LO))
        else $error("non-init job ran past four strobes");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && strobe.last) |=> (!r_busy && r_out.last && r_out_valid))
        else $error("job did not end on its last strobe");

endmodule

### src/char_lcd_4bit_sequencer.sv
// top level of the 4-bit character lcd sequencer
// Each accepted request (init, command byte, data byte, clear) turns into a run of
// enable strobes read out through the output register: two strobes per byte, high nibble
// first, twelve for init, and two more after a data byte that reaches the wrap column.
// A request is classified on entry, waits in a two-entry job queue, and is then
// loaded and expanded by the strobe sequencer at one strobe per cycle while the output
// register is empty or popped; the next job is loaded only after the last strobe of
// the current one. New requests are taken while the queue has room. Configuration
// writes are always ready; pulse_ticks is accepted but has no effect on any strobe.
module char_lcd_4bit_sequencer
    import lcd4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg r_cfg;
    t_job front_job;
    t_job q_job;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks   <= 16'd1000;
            r_cfg.wake_ticks     <= 16'd30000;
            r_cfg.init_cmd_ticks <= 16'd800;
            r_cfg.clear_ticks    <= 16'd10000;
            r_cfg.wrap_column    <= 5'd16;
            r_cfg.wrap_address   <= 8'hC1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SETTLE:   r_cfg.settle_ticks   <= i_cfg_data;
                CFG_WAKE:     r_cfg.wake_ticks     <= i_cfg_data;
                CFG_INIT_CMD: r_cfg.init_cmd_ticks <= i_cfg_data;
                CFG_CLEAR:    r_cfg.clear_ticks    <= i_cfg_data;
                CFG_WRAP_COL: r_cfg.wrap_column    <= i_cfg_data[4:0];
                CFG_WRAP_ADR: r_cfg.wrap_address   <= i_cfg_data[7:0];
                default:      r_cfg                <= r_cfg;
            endcase
        end
    end

    lcd4_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_item),
        .i_wrap_column (r_cfg.wrap_column),
        .o_job         (front_job)
    );

    lcd4_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    lcd4_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_item)
    );

endmodule

### dv/char_lcd_4bit_sequencer_test.sv
// self-checking testbench for the 4-bit character lcd sequencer
module char_lcd_4bit_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcd4_pkg::*;

    localparam int          RESET_CYCLES   = 10;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_GUARD   = 20;
    localparam int          PHASE_ITEMS    = 60;
    localparam int          REPORT_CAP     = 100;
    localparam logic [2:0]  CFG_UNUSED     = 3'd7;
    localparam logic [3:0]  WAKE_NIB       = 4'h3;
    localparam logic [3:0]  WAKE_NIB_LAST  = 4'h2;
    localparam logic [7:0]  FUNC_SET       = 8'h28;
    localparam logic [7:0]  DISPLAY_ON     = 8'h0C;
    localparam logic [7:0]  ENTRY_MODE     = 8'h06;
    localparam logic [7:0]  HOME_ADDR      = 8'h80;

    class strobe_predictor;
        t_out_item   expected_strobes[$];
        logic [15:0] pulse_ticks;
        logic [15:0] settle_ticks;
        logic [15:0] wake_ticks;
        logic [15:0] init_cmd_ticks;
        logic [15:0] clear_ticks;
        logic [4:0]  wrap_column;
        logic [7:0]  wrap_address;
        logic [4:0]  column;
        int          errors;

        function new();
            pulse_ticks    = 16'd25;
            settle_ticks   = 16'd1000;
            wake_ticks     = 16'd30000;
            init_cmd_ticks = 16'd800;
            clear_ticks    = 16'd10000;
            wrap_column    = 5'd16;
            wrap_address   = 8'hC1;
            column         = 5'd0;
            errors         = 0;
        endfunction

        function void report(string msg);
            if (errors < REPORT_CAP) begin
                $display("%0t mismatch: %s", $time, msg);
            end
            errors++;
        endfunction

        function void set_reg(logic [2:0] index, logic [15:0] data);
            case (index)
                CFG_PULSE:    pulse_ticks    = data;
                CFG_SETTLE:   settle_ticks   = data;
                CFG_WAKE:     wake_ticks     = data;
                CFG_INIT_CMD: init_cmd_ticks = data;
                CFG_CLEAR:    clear_ticks    = data;
                CFG_WRAP_COL: wrap_column    = data[4:0];
                CFG_WRAP_ADR: wrap_address   = data[7:0];
                default: ;
            endcase
        endfunction

        function void add_strobe(logic [3:0] nib, logic rs, logic [16:0] hold);
            t_out_item s;
            s.nibble     = nib;
            s.rs         = rs;
            s.wait_after = hold;
            s.last       = 1'b0;
            expected_strobes.push_back(s);
        endfunction

        // high nibble first, settle wait plus any extra after the low one
        function void add_byte(logic [7:0] b, logic rs, logic [15:0] extra);
            add_strobe(b[7:4], rs, 17'd0);
            add_strobe(b[3:0], rs, {1'b0, settle_ticks} + {1'b0, extra});
        endfunction

        function void note_request(t_in_item req);
            t_out_item tail;
            case (req.command)
                CMD_INIT: begin
                    for (int k = 0; k < 4; k++) begin
                        add_strobe((k == 3) ? WAKE_NIB_LAST : WAKE_NIB, 1'b0, {1'b0, wake_ticks});
                    end
                    add_byte(FUNC_SET, 1'b0, wake_ticks);
                    add_byte(DISPLAY_ON, 1'b0, init_cmd_ticks);
                    add_byte(ENTRY_MODE, 1'b0, init_cmd_ticks);
                    add_byte(HOME_ADDR, 1'b0, init_cmd_ticks);
                end
                CMD_BYTE: begin
                    add_byte(req.byte_value, 1'b0, 16'd0);
                end
                CMD_DATA: begin
                    if (req.start_of_text) begin
                        column = 5'd0;
                    end
                    add_byte(req.byte_value, 1'b1, 16'd0);
                    if (column < COLUMN_MAX) begin
                        column = column + 5'd1;
                    end
                    if (column == wrap_column) begin
                        add_byte(wrap_address, 1'b0, 16'd0);
                    end
                end
                default: begin
                    add_byte(CLEAR_BYTE, 1'b0, clear_ticks);
                end
            endcase
            tail = expected_strobes.pop_back();
            tail.last = 1'b1;
            expected_strobes.push_back(tail);
        endfunction

        function void check_strobe(t_out_item got);
            t_out_item want;
            if (expected_strobes.size() == 0) begin
                report($sformatf("strobe with nothing expected: %p", got));
                return;
            end
            want = expected_strobes.pop_front();
            if (got.nibble !== want.nibble) begin
                report($sformatf("nibble %h, expected %h", got.nibble, want.nibble));
            end
            if (got.rs !== want.rs) begin
                report($sformatf("rs %b, expected %b", got.rs, want.rs));
            end
            if (got.wait_after !== want.wait_after) begin
                report($sformatf("wait_after %0d, expected %0d", got.wait_after,
                                 want.wait_after));
            end
            if (got.last !== want.last) begin
                report($sformatf("last %b, expected %b", got.last, want.last));
            end
        endfunction

        function int pending();
            return expected_strobes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    strobe_predictor sb = new();

    int          burst_left  = 0;
    int          quiet_count = 0;
    int unsigned pop_left    = 0;
    logic [1:0]  pop_mode    = 2'd0;
    logic [1:0]  pop_tick    = 2'd0;

    char_lcd_4bit_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: stall pattern switches to a randomly chosen mode whenever its run counter expires
    always @(posedge i_clk) begin
        pop_tick <= pop_tick + 2'd1;
        if (pop_left == 0) begin
            pop_mode <= 2'($urandom_range(0, 3));
            pop_left <= $urandom_range(20, 200);
        end else begin
            pop_left <= pop_left - 1;
        end
        case (pop_mode)
            2'd0:    pop <= 1'b1;
            2'd1:    pop <= 1'($urandom_range(0, 1));
            2'd2:    pop <= (pop_tick == 2'd0);
            default: pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // result check and watchdog on transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                sb.check_strobe(o_item);
            end
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_count <= 0;
            end else if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    // sender bursts: after a burst, drop push for a random gap with junk on the item
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            push   <= 1'b0;
            i_item <= t_in_item'($urandom);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] val, input logic sot);
        t_in_item req;
        req.command       = cmd;
        req.byte_value    = val;
        req.start_of_text = sot;
        push   <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(req);
        pace();
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(index, data);
    endtask

    task automatic load_settings(input logic [15:0] pulse, input logic [15:0] settle,
                                 input logic [15:0] wake, input logic [15:0] init_cmd,
                                 input logic [15:0] clr, input logic [15:0] wrap_col,
                                 input logic [15:0] wrap_adr);
        write_reg(CFG_PULSE, pulse);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_WAKE, wake);
        write_reg(CFG_INIT_CMD, init_cmd);
        write_reg(CFG_CLEAR, clr);
        write_reg(CFG_WRAP_COL, wrap_col);
        write_reg(CFG_WRAP_ADR, wrap_adr);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the sender until every strobe is out, then let the sequencer go quiet
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_GUARD) @(posedge i_clk);
    endtask

    // mostly texts opened by a start flag; some lone commands, noise and broken texts
    task automatic run_traffic(input int n_items);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                send_request(CMD_INIT, 8'($urandom), 1'($urandom));
                sent++;
            end else if (pick <= 2) begin
                send_request(2'($urandom), 8'($urandom), 1'($urandom));
                sent++;
            end else if (pick == 3) begin
                send_request(CMD_CLEAR, 8'($urandom), 1'($urandom));
                sent++;
            end else if (pick == 4) begin
                send_request(CMD_BYTE, 8'($urandom), 1'($urandom));
                sent++;
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 40)
                                                  : $urandom_range(1, 20);
                for (int k = 0; k < len && sent < n_items; k++) begin
                    send_request(CMD_DATA, 8'($urandom),
                                 (k == 0) ? ($urandom_range(0, 9) != 0)
                                          : ($urandom_range(0, 31) == 0));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        push        <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_PULSE;
        i_cfg_data  <= 16'd0;
        i_rst_n     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, ignored operands, one text across the wrap
        send_request(CMD_INIT, 8'h00, 1'b0);
        send_request(CMD_INIT, 8'hFF, 1'b1);
        send_request(CMD_BYTE, 8'h00, 1'b0);
        send_request(CMD_BYTE, 8'hFF, 1'b1);
        send_request(CMD_CLEAR, 8'hA5, 1'b1);
        send_request(CMD_CLEAR, 8'h00, 1'b0);
        for (int k = 0; k < 18; k++) begin
            send_request(CMD_DATA, (k == 1) ? 8'h00 : (k == 2) ? 8'hFF : 8'(8'h40 + k),
                         (k == 0));
        end

        // all zero, wrap column zero never reached
        wait_idle();
        load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_traffic(PHASE_ITEMS);

        // all ones: longest waits, wrap at the saturated column
        wait_idle();
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(PHASE_ITEMS);

        // wrap after the first character
        wait_idle();
        load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'h0001, 16'($urandom));
        run_traffic(PHASE_ITEMS);

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            write_reg(CFG_UNUSED, 16'($urandom));
            load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), {11'($urandom), 5'($urandom_range(1, 20))},
                          16'($urandom));
            run_traffic(PHASE_ITEMS);
        end

        wait_idle();
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d strobes never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
